// File: design/length_prefixed_bundle_deframer_defines.svh
// ----------------------------------------------------------------------------
// Length-prefixed bundle deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_BUNDLE_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_BUNDLE_DEFRAMER_DEFINES_SVH

// A condition that must imply a property in the same cycle.
`define LPBD_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// A signal that must hold while a transaction is stalled.
`define LPBD_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// File: design/lpbd_pkg.sv
// ----------------------------------------------------------------------------
// Bundle deframer package
// Event, error and phase codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package lpbd_pkg;

    localparam logic [2:0] EV_PATH = 3'd0;
    localparam logic [2:0] EV_HEAD = 3'd1;
    localparam logic [2:0] EV_DATA = 3'd2;
    localparam logic [2:0] EV_OK   = 3'd3;
    localparam logic [2:0] EV_ERR  = 3'd4;

    localparam logic [2:0] ERR_SHORT     = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_COUNT     = 3'd2;
    localparam logic [2:0] ERR_PATH_LEN  = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
    localparam logic [2:0] ERR_TRUNC     = 3'd5;
    localparam logic [2:0] ERR_TRAILING  = 3'd6;

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_PLEN = 3'd1;
    localparam logic [2:0] PH_PATH = 3'd2;
    localparam logic [2:0] PH_DLEN = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [2:0] PH_DROP = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITEM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PATH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_OBJ  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS     = 3'd4;

    localparam logic [31:0] RST_MAGIC    = 32'd0;
    localparam logic [31:0] RST_MAX_ITEM = 32'd65535;
    localparam logic [31:0] RST_MAX_PATH = 32'd4096;
    localparam logic [63:0] RST_MAX_OBJ  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] RST_MISS     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 4;

    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] max_item;
        logic [31:0] max_path;
        logic [63:0] max_obj;
        logic [63:0] miss;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] item_number;
        logic [31:0] path_length;
        logic [63:0] object_length;
        logic        object_missing;
        logic [2:0]  error_code;
    } result_t;

    // One parsed byte: a full first result and an optional closing result.
    typedef struct packed {
        logic        two;
        result_t     first;
        logic [2:0]  end_kind;
        logic [31:0] end_item;
        logic [2:0]  end_error;
    } entry_t;

    function automatic result_t make_end(input logic [2:0] kind, input logic [31:0] item,
                                         input logic [2:0] err);
        result_t r;
        r = '0;
        r.kind        = kind;
        r.item_number = item;
        r.error_code  = err;
        return r;
    endfunction

endpackage

// File: design/lpbd_parser.sv
// ----------------------------------------------------------------------------
// Bundle deframer parser
// Parse state and one-byte step logic producing up to two results per byte.
// ----------------------------------------------------------------------------
module lpbd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  lpbd_pkg::cfg_t cfg,
    input  logic           step,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    output logic           push,
    output lpbd_pkg::entry_t entry
);
    import lpbd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [63:0] fshift_reg, fshift_next;
    logic [31:0] items_reg, items_next;
    logic [31:0] item_reg, item_next;
    logic [31:0] path_left_reg, path_left_next;
    logic [31:0] held_plen_reg, held_plen_next;
    logic [63:0] data_left_reg, data_left_next;

    logic [63:0] assembled;
    logic        has0;
    logic        has_end;
    logic        is_err;
    logic        quiet;
    logic        finish;
    result_t     r0;
    logic [2:0]  end_kind;
    logic [2:0]  end_err;

    assign assembled = fshift_reg | ({56'd0, in_byte} << {fcnt_reg[2:0], 3'b000});

    always_comb
    begin
        phase_next     = phase_reg;
        fcnt_next      = fcnt_reg;
        fshift_next    = fshift_reg;
        items_next     = items_reg;
        item_next      = item_reg;
        path_left_next = path_left_reg;
        held_plen_next = held_plen_reg;
        data_left_next = data_left_reg;
        has0           = 1'b0;
        is_err         = 1'b0;
        quiet          = 1'b0;
        finish         = 1'b0;
        r0             = '0;
        r0.item_number = item_reg;

        unique case (phase_reg)
            PH_HDR:
            begin
                fshift_next = assembled;
                fcnt_next   = fcnt_reg + 4'd1;
                if (fcnt_reg != 4'd7)
                begin
                    if (in_last)
                    begin
                        has0          = 1'b1;
                        is_err        = 1'b1;
                        r0.kind       = EV_ERR;
                        r0.error_code = ERR_SHORT;
                    end
                end
                else
                begin
                    fcnt_next   = 4'd0;
                    fshift_next = '0;
                    if (assembled[31:0] != cfg.magic)
                    begin
                        has0          = 1'b1;
                        is_err        = 1'b1;
                        r0.kind       = EV_ERR;
                        r0.error_code = ERR_MAGIC;
                    end
                    else if (assembled[63:32] > cfg.max_item)
                    begin
                        has0          = 1'b1;
                        is_err        = 1'b1;
                        r0.kind       = EV_ERR;
                        r0.error_code = ERR_COUNT;
                    end
                    else
                    begin
                        items_next = assembled[63:32];
                        item_next  = '0;
                        phase_next = (assembled[63:32] != 32'd0) ? PH_PLEN : PH_DONE;
                    end
                end
            end
            PH_PLEN:
            begin
                fshift_next = assembled;
                fcnt_next   = fcnt_reg + 4'd1;
                if (fcnt_reg == 4'd3)
                begin
                    fcnt_next   = 4'd0;
                    fshift_next = '0;
                    if (assembled[31:0] == 32'd0 || assembled[31:0] > cfg.max_path)
                    begin
                        has0          = 1'b1;
                        is_err        = 1'b1;
                        r0.kind       = EV_ERR;
                        r0.error_code = ERR_PATH_LEN;
                    end
                    else
                    begin
                        held_plen_next = assembled[31:0];
                        path_left_next = assembled[31:0];
                        phase_next     = PH_PATH;
                    end
                end
            end
            PH_PATH:
            begin
                has0           = 1'b1;
                r0.kind        = EV_PATH;
                r0.byte_value  = in_byte;
                r0.path_length = held_plen_reg;
                path_left_next = path_left_reg - 32'd1;
                if (path_left_next == 32'd0)
                begin
                    fcnt_next   = 4'd0;
                    fshift_next = '0;
                    phase_next  = PH_DLEN;
                end
            end
            PH_DLEN:
            begin
                fshift_next = assembled;
                fcnt_next   = fcnt_reg + 4'd1;
                if (fcnt_reg == 4'd7)
                begin
                    fcnt_next   = 4'd0;
                    fshift_next = '0;
                    if (assembled == cfg.miss)
                    begin
                        has0              = 1'b1;
                        r0.kind           = EV_HEAD;
                        r0.path_length    = held_plen_reg;
                        r0.object_missing = 1'b1;
                        finish            = 1'b1;
                    end
                    else if (assembled > cfg.max_obj)
                    begin
                        has0          = 1'b1;
                        is_err        = 1'b1;
                        r0.kind       = EV_ERR;
                        r0.error_code = ERR_TOO_LARGE;
                    end
                    else
                    begin
                        has0             = 1'b1;
                        r0.kind          = EV_HEAD;
                        r0.path_length   = held_plen_reg;
                        r0.object_length = assembled;
                        if (assembled == 64'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            data_left_next = assembled;
                            phase_next     = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                has0           = 1'b1;
                r0.kind        = EV_DATA;
                r0.byte_value  = in_byte;
                r0.path_length = held_plen_reg;
                data_left_next = data_left_reg - 64'd1;
                if (data_left_next == 64'd0)
                begin
                    finish = 1'b1;
                end
            end
            PH_DONE:
            begin
                has0          = 1'b1;
                is_err        = 1'b1;
                r0.kind       = EV_ERR;
                r0.error_code = ERR_TRAILING;
            end
            default:
            begin
                quiet = 1'b1;
            end
        endcase

        if (finish)
        begin
            items_next     = items_reg - 32'd1;
            item_next      = item_reg + 32'd1;
            held_plen_next = '0;
            data_left_next = '0;
            fcnt_next      = 4'd0;
            fshift_next    = '0;
            phase_next     = (items_next != 32'd0) ? PH_PLEN : PH_DONE;
        end

        has_end  = !is_err && !quiet && in_last;
        end_kind = (phase_next == PH_DONE) ? EV_OK : EV_ERR;
        end_err  = (phase_next == PH_DONE) ? ERR_SHORT : ERR_TRUNC;

        entry.two       = has0 && has_end;
        entry.first     = has0 ? r0 : make_end(end_kind, item_next, end_err);
        entry.end_kind  = end_kind;
        entry.end_item  = item_next;
        entry.end_error = end_err;
        push            = step && (has0 || has_end);

        if (in_last)
        begin
            phase_next     = PH_HDR;
            fcnt_next      = '0;
            fshift_next    = '0;
            items_next     = '0;
            item_next      = '0;
            path_left_next = '0;
            held_plen_next = '0;
            data_left_next = '0;
        end
        else if (is_err)
        begin
            phase_next = PH_DROP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            fcnt_reg      <= '0;
            fshift_reg    <= '0;
            items_reg     <= '0;
            item_reg      <= '0;
            path_left_reg <= '0;
            held_plen_reg <= '0;
            data_left_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            fcnt_reg      <= fcnt_next;
            fshift_reg    <= fshift_next;
            items_reg     <= items_next;
            item_reg      <= item_next;
            path_left_reg <= path_left_next;
            held_plen_reg <= held_plen_next;
            data_left_reg <= data_left_next;
        end
    end

endmodule

// File: design/lpbd_out_queue.sv
// ----------------------------------------------------------------------------
// Bundle deframer result queue
// Two-entry queue of parsed bytes, each sent as one or two transactions.
// ----------------------------------------------------------------------------
module lpbd_out_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  lpbd_pkg::entry_t                    entry,
    output logic                                ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpbd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [lpbd_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);
    import lpbd_pkg::*;

    entry_t      mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        sel_reg, sel_next;
    entry_t      head;
    result_t     cur;
    logic        xfer;
    logic        pop;

    assign head     = mem[rd_ptr_reg];
    assign cur      = sel_reg ? make_end(head.end_kind, head.end_item, head.end_error)
                              : head.first;
    assign m_tvalid = (count_reg != 2'd0);
    assign ready    = (count_reg != 2'd2);
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && (!head.two || sel_reg);

    assign m_tdata = {5'd0, cur.error_code, cur.object_length, cur.path_length,
                      cur.item_number, cur.byte_value};
    assign m_tuser = {cur.object_missing, cur.kind};
    assign m_tlast = !head.two || sel_reg;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        sel_next    = sel_reg;
        if (xfer)
        begin
            sel_next = head.two && !sel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
            sel_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

endmodule

// File: design/length_prefixed_bundle_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed bundle deframer
// Checks a bundle header, splits items and passes path and data bytes on.
//
//   Channel   Direction  tdata (lowest bit up)                     tuser / tlast
//   s_*       in         stream_byte                               - / end_of_stream
//   m_*       out        byte_value, item_number, path_length,     event_kind,
//                        object_length, error_code, zero pad       object_missing / run_last
//   cfg_*     in         register write, no read-back              -
//
// One byte is taken per cycle while the result queue has room; a byte is parsed
// from the input register, and its results leave from a two-entry queue.
// A byte that yields two results leaves as two output transactions.
// Reset clears the parse state and loads the register defaults.
// A stalled output stops input only once the result queue is full.
// ----------------------------------------------------------------------------
module length_prefixed_bundle_deframer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // stream_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // byte_value, item_number, path_length, object_length, error_code, pad
    output logic [lpbd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [lpbd_pkg::OUT_USER_W-1:0]     m_tuser,   // event_kind, object_missing
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [lpbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpbd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lpbd_pkg::*;

    cfg_t        cfg_reg;
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        q_ready;
    logic        step;
    logic        push;
    entry_t      entry;

    assign step     = in_vld_reg && q_ready;
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic    <= RST_MAGIC;
            cfg_reg.max_item <= RST_MAX_ITEM;
            cfg_reg.max_path <= RST_MAX_PATH;
            cfg_reg.max_obj  <= RST_MAX_OBJ;
            cfg_reg.miss     <= RST_MISS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAGIC:    cfg_reg.magic    <= cfg_data[31:0];
                REG_MAX_ITEM: cfg_reg.max_item <= cfg_data[31:0];
                REG_MAX_PATH: cfg_reg.max_path <= cfg_data[31:0];
                REG_MAX_OBJ:  cfg_reg.max_obj  <= cfg_data;
                REG_MISS:     cfg_reg.miss     <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    lpbd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (step),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .push    (push),
        .entry   (entry)
    );

    lpbd_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry    (entry),
        .ready    (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/lpbd_checker.sv
// ----------------------------------------------------------------------------
// Bundle deframer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_bundle_deframer_defines.svh"

module lpbd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lpbd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [lpbd_pkg::OUT_USER_W-1:0]   m_tuser,
    input logic                              m_tlast
);
    import lpbd_pkg::*;

    `LPBD_ASSERT_HOLD(a_stall_hold, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast}, "stalled result transaction changed")

    `LPBD_ASSERT_IMPLY(a_miss_zero_len, m_tvalid && m_tuser[3], m_tuser[2:0] == EV_HEAD && m_tdata[135:72] == 64'd0, "missing object with nonzero length")

    `LPBD_ASSERT_IMPLY(a_err_fields, m_tvalid && m_tuser[2:0] == EV_ERR, m_tdata[71:40] == 32'd0 && m_tdata[7:0] == 8'd0 && m_tlast, "error transaction carries payload or is not last")

    `LPBD_ASSERT_IMPLY(a_ok_last, m_tvalid && m_tuser[2:0] == EV_OK, m_tlast && m_tdata[138:136] == ERR_SHORT, "bundle ok transaction not last")

endmodule

bind length_prefixed_bundle_deframer lpbd_checker u_lpbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: verif/bundle_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bundle deframer event checker
// Follows the register writes and the input byte stream, works out the events
// that each accepted byte must produce, and compares every output transaction
// with the oldest event still outstanding.
// ----------------------------------------------------------------------------
module bundle_event_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // stream_byte
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // byte_value, item_number, path_length, object_length, error_code, pad
    input  logic [lpbd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [lpbd_pkg::OUT_USER_W-1:0]     m_tuser,   // event_kind, object_missing
    input  logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [lpbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked
);
    import lpbd_pkg::*;

    typedef struct packed {
        result_t ev;
        logic    last;
    } outcome_t;

    outcome_t    expected_q[$];
    result_t     step_events[$];

    logic [31:0] cfg_magic;
    logic [31:0] cfg_max_item;
    logic [31:0] cfg_max_path;
    logic [63:0] cfg_max_obj;
    logic [63:0] cfg_miss;

    logic [2:0]  phase;
    logic [3:0]  byte_cnt;
    logic [63:0] gather;
    logic [31:0] items_left;
    logic [31:0] item_idx;
    logic [31:0] path_left;
    logic [31:0] held_plen;
    logic [63:0] data_left;

    task automatic restart_parse();
        phase      = PH_HDR;
        byte_cnt   = '0;
        gather     = '0;
        items_left = '0;
        item_idx   = '0;
        path_left  = '0;
        held_plen  = '0;
        data_left  = '0;
    endtask

    task automatic drop_field();
        byte_cnt = '0;
        gather   = '0;
    endtask

    task automatic shift_in(input logic [7:0] b);
        gather   = gather | ({56'd0, b} << {byte_cnt[2:0], 3'b000});
        byte_cnt = byte_cnt + 4'd1;
    endtask

    task automatic close_item();
        items_left = items_left - 32'd1;
        item_idx   = item_idx + 32'd1;
        held_plen  = '0;
        data_left  = '0;
        drop_field();
        phase = (items_left != 0) ? PH_PLEN : PH_DONE;
    endtask

    function automatic result_t make_event(input logic [2:0] kind, input logic [7:0] b,
                                           input logic [63:0] olen, input logic miss,
                                           input logic [2:0] err);
        result_t r;
        r                = '0;
        r.kind           = kind;
        r.byte_value     = (kind == EV_PATH || kind == EV_DATA) ? b : 8'd0;
        r.item_number    = item_idx;
        r.path_length    = (kind <= EV_DATA) ? held_plen : 32'd0;
        r.object_length  = (kind == EV_HEAD) ? olen : 64'd0;
        r.object_missing = (kind == EV_HEAD) ? miss : 1'b0;
        r.error_code     = (kind == EV_ERR) ? err : 3'd0;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic eob);
        logic [31:0] hdr_magic;
        logic [31:0] hdr_count;
        logic [31:0] plen;
        logic [63:0] dlen;
        logic        failed;
        logic        silent;
        outcome_t    entry;
        int          i;
        failed = 1'b0;
        silent = 1'b0;
        step_events.delete();
        case (phase)
            PH_HDR:
            begin
                shift_in(b);
                if (byte_cnt < 4'd8)
                begin
                    if (eob)
                    begin
                        step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0, ERR_SHORT));
                        failed = 1'b1;
                    end
                end
                else
                begin
                    hdr_magic = gather[31:0];
                    hdr_count = gather[63:32];
                    drop_field();
                    if (hdr_magic != cfg_magic)
                    begin
                        step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0, ERR_MAGIC));
                        failed = 1'b1;
                    end
                    else if (hdr_count > cfg_max_item)
                    begin
                        step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0, ERR_COUNT));
                        failed = 1'b1;
                    end
                    else
                    begin
                        items_left = hdr_count;
                        item_idx   = '0;
                        phase      = (hdr_count != 0) ? PH_PLEN : PH_DONE;
                    end
                end
            end
            PH_PLEN:
            begin
                shift_in(b);
                if (byte_cnt >= 4'd4)
                begin
                    plen = gather[31:0];
                    drop_field();
                    if (plen == 0 || plen > cfg_max_path)
                    begin
                        step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0,
                                                         ERR_PATH_LEN));
                        failed = 1'b1;
                    end
                    else
                    begin
                        held_plen = plen;
                        path_left = plen;
                        phase     = PH_PATH;
                    end
                end
            end
            PH_PATH:
            begin
                step_events.push_back(make_event(EV_PATH, b, 64'd0, 1'b0, 3'd0));
                path_left = path_left - 32'd1;
                if (path_left == 0)
                begin
                    drop_field();
                    phase = PH_DLEN;
                end
            end
            PH_DLEN:
            begin
                shift_in(b);
                if (byte_cnt >= 4'd8)
                begin
                    dlen = gather;
                    drop_field();
                    if (dlen == cfg_miss)
                    begin
                        step_events.push_back(make_event(EV_HEAD, 8'd0, 64'd0, 1'b1, 3'd0));
                        close_item();
                    end
                    else if (dlen > cfg_max_obj)
                    begin
                        step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0,
                                                         ERR_TOO_LARGE));
                        failed = 1'b1;
                    end
                    else
                    begin
                        step_events.push_back(make_event(EV_HEAD, 8'd0, dlen, 1'b0, 3'd0));
                        if (dlen == 0)
                            close_item();
                        else
                        begin
                            data_left = dlen;
                            phase     = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                step_events.push_back(make_event(EV_DATA, b, 64'd0, 1'b0, 3'd0));
                data_left = data_left - 64'd1;
                if (data_left == 0)
                    close_item();
            end
            PH_DONE:
            begin
                step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0, ERR_TRAILING));
                failed = 1'b1;
            end
            default:
            begin
                silent = 1'b1;
            end
        endcase

        if (!failed && !silent && eob)
        begin
            if (phase == PH_DONE)
                step_events.push_back(make_event(EV_OK, 8'd0, 64'd0, 1'b0, 3'd0));
            else
                step_events.push_back(make_event(EV_ERR, 8'd0, 64'd0, 1'b0, ERR_TRUNC));
        end

        for (i = 0; i < step_events.size(); i++)
        begin
            entry.ev   = step_events[i];
            entry.last = (i == step_events.size() - 1);
            expected_q.push_back(entry);
        end

        if (eob)
            restart_parse();
        else if (failed)
            phase = PH_DROP;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        fail_count++;
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result();
        outcome_t want;
        result_t  got;
        if (expected_q.size() == 0)
        begin
            report("event_kind of a transaction with nothing outstanding",
                   64'(m_tuser[2:0]), 64'd0);
            return;
        end
        want               = expected_q.pop_front();
        got.kind           = m_tuser[2:0];
        got.object_missing = m_tuser[3];
        got.byte_value     = m_tdata[7:0];
        got.item_number    = m_tdata[39:8];
        got.path_length    = m_tdata[71:40];
        got.object_length  = m_tdata[135:72];
        got.error_code     = m_tdata[138:136];
        if (got.kind != want.ev.kind)
            report("event_kind", 64'(got.kind), 64'(want.ev.kind));
        if (got.byte_value != want.ev.byte_value)
            report("byte_value", 64'(got.byte_value), 64'(want.ev.byte_value));
        if (got.item_number != want.ev.item_number)
            report("item_number", 64'(got.item_number), 64'(want.ev.item_number));
        if (got.path_length != want.ev.path_length)
            report("path_length", 64'(got.path_length), 64'(want.ev.path_length));
        if (got.object_length != want.ev.object_length)
            report("object_length", got.object_length, want.ev.object_length);
        if (got.object_missing != want.ev.object_missing)
            report("object_missing", 64'(got.object_missing), 64'(want.ev.object_missing));
        if (got.error_code != want.ev.error_code)
            report("error_code", 64'(got.error_code), 64'(want.ev.error_code));
        if (m_tlast != want.last)
            report("run_last", 64'(m_tlast), 64'(want.last));
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_magic    = RST_MAGIC;
            cfg_max_item = RST_MAX_ITEM;
            cfg_max_path = RST_MAX_PATH;
            cfg_max_obj  = RST_MAX_OBJ;
            cfg_miss     = RST_MISS;
            restart_parse();
            expected_q.delete();
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAGIC:    cfg_magic    = cfg_data[31:0];
                    REG_MAX_ITEM: cfg_max_item = cfg_data[31:0];
                    REG_MAX_PATH: cfg_max_path = cfg_data[31:0];
                    REG_MAX_OBJ:  cfg_max_obj  = cfg_data;
                    REG_MISS:     cfg_miss     = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = expected_q.size();
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bundle deframer testbench
// Sends directed and random bundles, well formed and broken, through the
// deframer under a series of register settings, with random gaps on the
// input and random stalls on the output; the event checker scores the results.
// ----------------------------------------------------------------------------
module testbench;
    import lpbd_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT,
        FLAW_MAGIC,
        FLAW_COUNT,
        FLAW_PATH,
        FLAW_LARGE,
        FLAW_CUT,
        FLAW_TAIL,
        FLAW_NOISE
    } flaw_e;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [7:0]                 s_tdata;
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_DATA_W-1:0]      m_tdata;
    logic [OUT_USER_W-1:0]      m_tuser;
    logic                       m_tlast;
    logic                       cfg_we;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int                         fail_count;
    int                         pending;
    int                         checked;

    logic [7:0]                 bundle_q[$];
    int                         bytes_sent;
    int                         bundles_sent;
    int                         settings_used;
    bit                         calm;
    int                         send_gap_pct;
    int                         ready_stall_pct;
    int                         stall_left;

    logic [31:0]                mg_word;
    logic [31:0]                lim_items;
    logic [31:0]                lim_path;
    logic [63:0]                lim_obj;
    logic [63:0]                miss_len;

    length_prefixed_bundle_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bundle_event_checker u_event_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Output stalls come in bursts, counted down by stall_left.
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 99) < ready_stall_pct)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] mg, input logic [31:0] items,
                                  input logic [31:0] path, input logic [63:0] obj,
                                  input logic [63:0] miss);
        write_reg(REG_MAGIC, {32'd0, mg});
        write_reg(REG_MAX_ITEM, {32'd0, items});
        write_reg(REG_MAX_PATH, {32'd0, path});
        write_reg(REG_MAX_OBJ, obj);
        write_reg(REG_MISS, miss);
        cfg_we    <= 1'b0;
        mg_word   = mg;
        lim_items = items;
        lim_path  = path;
        lim_obj   = obj;
        miss_len  = miss;
        settings_used++;
    endtask

    task automatic put_le(input logic [63:0] value, input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            bundle_q.push_back(value[8*i +: 8]);
    endtask

    task automatic put_random(input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            bundle_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_header(input logic [31:0] mg, input logic [31:0] count);
        put_le({32'd0, mg}, 4);
        put_le({32'd0, count}, 4);
    endtask

    task automatic put_item();
        int          plen_cap;
        int          dcap;
        logic [31:0] plen;
        logic [63:0] dlen;
        plen_cap = (lim_path < 6) ? int'(lim_path) : 6;
        dcap     = (lim_obj < 8) ? int'(lim_obj) : 8;
        plen     = $urandom_range(1, plen_cap);
        put_le({32'd0, plen}, 4);
        put_random(plen);
        if ($urandom_range(0, 6) == 0)
            dlen = miss_len;
        else
            dlen = 64'($urandom_range(0, dcap));
        put_le(dlen, 8);
        if (dlen != miss_len)
            put_random(int'(dlen));
    endtask

    task automatic put_items(input int count);
        int i;
        for (i = 0; i < count; i++)
            put_item();
    endtask

    task automatic gen_bundle();
        int          roll;
        int          cap;
        int          count;
        int          good;
        int          keep;
        flaw_e       flaw;
        logic [31:0] bad_plen;
        roll = $urandom_range(0, 99);
        cap  = (lim_items < 4) ? int'(lim_items) : 4;
        if (roll < 70)
            flaw = FLAW_NONE;
        else if (roll < 74)
            flaw = FLAW_SHORT;
        else if (roll < 78)
            flaw = FLAW_MAGIC;
        else if (roll < 81)
            flaw = FLAW_COUNT;
        else if (roll < 85)
            flaw = FLAW_PATH;
        else if (roll < 89)
            flaw = FLAW_LARGE;
        else if (roll < 95)
            flaw = FLAW_CUT;
        else if (roll < 98)
            flaw = FLAW_TAIL;
        else
            flaw = FLAW_NOISE;
        if (flaw == FLAW_COUNT && lim_items == 32'hFFFF_FFFF)
            flaw = FLAW_CUT;
        if (flaw == FLAW_PATH && lim_items == 0)
            flaw = FLAW_NOISE;
        if (flaw == FLAW_LARGE &&
            (lim_items == 0 || lim_obj == 64'hFFFF_FFFF_FFFF_FFFF || lim_obj + 1 == miss_len))
            flaw = FLAW_CUT;

        count = $urandom_range(0, cap);
        case (flaw)
            FLAW_NONE, FLAW_TAIL:
            begin
                put_header(mg_word, count);
                put_items(count);
                if (flaw == FLAW_TAIL)
                    put_random($urandom_range(1, 3));
            end
            FLAW_SHORT:
            begin
                put_header(mg_word, count);
                keep = $urandom_range(1, 7);
                while (bundle_q.size() > keep)
                    void'(bundle_q.pop_back());
            end
            FLAW_MAGIC:
            begin
                put_header(mg_word ^ (32'd1 << $urandom_range(0, 31)), count);
                put_random($urandom_range(0, 4));
            end
            FLAW_COUNT:
            begin
                put_header(mg_word, lim_items + 32'd1);
                put_random($urandom_range(0, 4));
            end
            FLAW_PATH:
            begin
                count = $urandom_range(1, cap);
                good  = $urandom_range(0, count - 1);
                put_header(mg_word, count);
                put_items(good);
                if (lim_path == 32'hFFFF_FFFF || $urandom_range(0, 1) == 0)
                    bad_plen = 32'd0;
                else
                    bad_plen = lim_path + 32'd1;
                put_le({32'd0, bad_plen}, 4);
                put_random($urandom_range(0, 3));
            end
            FLAW_LARGE:
            begin
                count = $urandom_range(1, cap);
                good  = $urandom_range(0, count - 1);
                put_header(mg_word, count);
                put_items(good);
                put_le(64'd1, 4);
                put_random(1);
                put_le(lim_obj + 64'd1, 8);
                put_random($urandom_range(0, 3));
            end
            FLAW_CUT:
            begin
                if (cap >= 1 && $urandom_range(0, 1) == 0)
                begin
                    // An item declares the largest allowed path or object length, and the bundle is cut short after it.
                    count = $urandom_range(1, cap);
                    put_header(mg_word, count);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        put_le({32'd0, lim_path}, 4);
                        put_random($urandom_range(1, 5));
                    end
                    else
                    begin
                        put_le(64'd1, 4);
                        put_random(1);
                        put_le(lim_obj, 8);
                        put_random($urandom_range(0, 4));
                    end
                end
                else
                begin
                    put_header(mg_word, count);
                    put_items(count);
                    keep = $urandom_range(1, bundle_q.size() - 1);
                    while (bundle_q.size() > keep)
                        void'(bundle_q.pop_back());
                end
            end
            default:
            begin
                put_random($urandom_range(1, 12));
            end
        endcase
    endtask

    // The end-of-stream flag rides on the final byte of the bundle.
    task automatic send_bundle();
        int i;
        for (i = 0; i < bundle_q.size(); i++)
        begin
            if (!calm && $urandom_range(0, 99) < send_gap_pct)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= bundle_q[i];
            s_tlast  <= (i == bundle_q.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
            bytes_sent++;
        end
        bundle_q.delete();
        bundles_sent++;
    endtask

    // Header bytes produce no events, so the task idles on after nothing is outstanding.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    initial
    begin
        int ph;
        int goal;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'd0;
        s_tlast         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        calm            = 1'b0;
        send_gap_pct    = 20;
        ready_stall_pct = 20;
        bytes_sent      = 0;
        bundles_sent    = 0;
        settings_used   = 1;
        mg_word         = RST_MAGIC;
        lim_items       = RST_MAX_ITEM;
        lim_path        = RST_MAX_PATH;
        lim_obj         = RST_MAX_OBJ;
        miss_len        = RST_MISS;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bundles under the reset register values.
        bundle_q.push_back(8'h00);
        send_bundle();
        put_le(64'hFF_FFFF_FFFF_FFFF, 7);
        send_bundle();
        put_le(64'd0, 4);
        send_bundle();
        put_header(32'hFFFF_FFFF, 32'd0);
        send_bundle();
        put_header(mg_word, 32'd65536);
        bundle_q.push_back(8'h00);
        bundle_q.push_back(8'hFF);
        send_bundle();
        put_header(mg_word, 32'd0);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd0, 4);
        bundle_q.push_back(8'hAA);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd4097, 4);
        send_bundle();
        put_header(mg_word, 32'd2);
        put_le(64'd1, 4);
        bundle_q.push_back(8'h00);
        put_le(RST_MISS, 8);
        put_le(64'd2, 4);
        bundle_q.push_back(8'hFF);
        bundle_q.push_back(8'h00);
        put_le(64'd2, 8);
        bundle_q.push_back(8'hFF);
        bundle_q.push_back(8'h00);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd1, 4);
        bundle_q.push_back(8'h7E);
        put_le(64'h1_0000_0000, 8);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd1, 4);
        bundle_q.push_back(8'h55);
        put_le(64'd0, 8);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd1, 4);
        bundle_q.push_back(8'h01);
        put_le(64'hFFFF_FFFF, 8);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd1, 4);
        bundle_q.push_back(8'h80);
        put_le(64'd1, 8);
        bundle_q.push_back(8'h3C);
        bundle_q.push_back(8'hFF);
        bundle_q.push_back(8'h00);
        send_bundle();
        put_header(mg_word, 32'd0);
        bundle_q.push_back(8'h12);
        send_bundle();
        put_header(mg_word, 32'd3);
        put_le(64'd4096, 4);
        bundle_q.push_back(8'hC3);
        bundle_q.push_back(8'h5A);
        send_bundle();
        put_header(mg_word, 32'd1);
        put_le(64'd1, 4);
        bundle_q.push_back(8'h41);
        bundle_q.push_back(8'h03);
        send_bundle();
        settle();

        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                    apply_settings($urandom, RST_MAX_ITEM, RST_MAX_PATH, RST_MAX_OBJ, RST_MISS);
                1:
                    apply_settings(32'hFFFF_FFFF, 32'd0, 32'd1, 64'd0, 64'd0);
                2:
                    apply_settings(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom});
                default:
                    apply_settings($urandom, $urandom_range(1, 6), $urandom_range(1, 8),
                                   64'($urandom_range(0, 12)),
                                   ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 12))
                                                               : {$urandom, $urandom});
            endcase
            calm            = (ph == 6);
            send_gap_pct    = pick_idle_pct();
            ready_stall_pct = pick_idle_pct();
            goal            = bytes_sent + 200;
            while (bytes_sent < goal)
            begin
                gen_bundle();
                send_bundle();
            end
            settle();
        end

        $display("Sent %0d bytes in %0d bundles under %0d register settings.",
                 bytes_sent, bundles_sent, settings_used);
        $display("Checked %0d events; %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
